@@ hw/rtl/qer_pkg.sv @@
// Shared types, constants and the arctangent table for the quaternion reframe pipeline.
`timescale 1ns / 1ps
`default_nettype none

package qer_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    // widths: Euler terms, CORDIC x/y datapath, CORDIC angle accumulator, sqrt datapath
    localparam int TW  = 36;
    localparam int XW  = 38;
    localparam int ZW  = 34;
    localparam int SQW = 58;

    localparam int Q28_ONE      = 268435456;
    localparam int QUARTER_TURN = 1073741824;
    localparam int CORDIC_GAIN  = 163008219;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [SQW-1:0] v;
        logic [SQW-1:0] r;
    } isq_t;

    typedef struct packed {
        logic signed [TW-1:0] sinr;
        logic signed [TW-1:0] cosr;
        logic signed [TW-1:0] sinp;
        logic signed [TW-1:0] siny;
        logic signed [TW-1:0] cosy;
        logic                 sat;
    } term_t;

    // arctangent of 2^-i, binary angle with 2^31 = pi
    function automatic int atan_entry(input int i);
        int a;
        case (i)
            0:       a = 536870912;
            1:       a = 316933406;
            2:       a = 167458907;
            3:       a = 85004756;
            4:       a = 42667331;
            5:       a = 21354465;
            6:       a = 10680862;
            7:       a = 5340245;
            8:       a = 2670163;
            9:       a = 1335087;
            10:      a = 667544;
            11:      a = 333772;
            12:      a = 166886;
            13:      a = 83443;
            14:      a = 41722;
            15:      a = 20861;
            16:      a = 10430;
            17:      a = 5215;
            18:      a = 2608;
            19:      a = 1304;
            20:      a = 652;
            21:      a = 326;
            22:      a = 163;
            23:      a = 81;
            default: a = 0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qer_isqrt_cell.sv @@
// One digit step of the restoring integer square root chain.
`timescale 1ns / 1ps
`default_nettype none

module qer_isqrt_cell #(
    parameter int K = 0
) (
    input  wire logic         aclk,
    input  wire logic         ce,
    input  wire qer_pkg::isq_t d_in,
    output qer_pkg::isq_t     d_out
);
    import qer_pkg::*;

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

    isq_t           cell_reg;
    isq_t           cell_next;
    logic [SQW-1:0] trial;

    always_comb begin
        trial = d_in.r + BIT;
        if (d_in.v >= trial) begin
            cell_next.v = d_in.v - trial;
            cell_next.r = (d_in.r >> 1) + BIT;
        end else begin
            cell_next.v = d_in.v;
            cell_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

`default_nettype wire

@@ hw/rtl/qer_cordic_cell.sv @@
// One micro-rotation of a CORDIC chain, vectoring or rotation mode.
`timescale 1ns / 1ps
`default_nettype none

module qer_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b1
) (
    input  wire logic      aclk,
    input  wire logic      ce,
    input  wire qer_pkg::vec_t d_in,
    output qer_pkg::vec_t  d_out
);
    import qer_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(STAGE));

    vec_t                 cell_reg;
    vec_t                 cell_next;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 ccw;

    always_comb begin
        xi  = d_in.x;
        yi  = d_in.y;
        xs  = xi >>> STAGE;
        ys  = yi >>> STAGE;
        // vectoring drives y to zero, rotation drives z to zero
        ccw = VECTOR ? yi[XW-1] : !d_in.z[ZW-1];
        if (ccw) begin
            cell_next.x = xi - ys;
            cell_next.y = yi + xs;
            cell_next.z = d_in.z - ATAN;
        end else begin
            cell_next.x = xi + ys;
            cell_next.y = yi - xs;
            cell_next.z = d_in.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

`default_nettype wire

@@ hw/rtl/quaternion_euler_reframe.sv @@
// Top level: quaternion to roll/pitch/yaw and re-framed quaternion pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Converts one attitude quaternion (w,x,y,z in Q1.14) per transfer into roll, pitch and yaw
// binary angles (32768 = pi), a pitch clamp flag, and the quaternion rebuilt from roll,
// -pitch and -yaw. Fully pipelined: one quaternion is taken every clock unless the output
// skid entry is full, which stalls the whole pipeline. Its depth is set by the 29-cell
// square root chain and the vectoring and rotation CORDIC cell rows.
// A two-entry output buffer keeps the input open while one result waits to be taken.
module quaternion_euler_reframe #(
    parameter int CORDIC_STAGES = qer_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // roll_angle, pitch_angle, yaw_angle, out_w, out_x,
                                         // out_y, out_z
    output logic [0:0]        m_tuser    // pitch_saturated
);
    import qer_pkg::*;

    localparam int N   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int LAT = 36 + 2 * N;
    localparam int SQN = 29;

    typedef struct packed {
        vec_t v;
        logic zero;
    } pre_t;

    typedef struct packed {
        logic [2:0] zero;
        logic       sat;
        logic       pos;
    } vside_t;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic        sat;
    } aside_t;

    function automatic pre_t prerot(input logic signed [TW-1:0] y,
                                    input logic signed [TW-1:0] x);
        pre_t p;
        p.zero = 1'b0;
        if (x == '0 && y == '0) begin
            p.zero = 1'b1;
            p.v.x  = '0;
            p.v.y  = '0;
            p.v.z  = '0;
        end else if (x < 0) begin
            if (y >= 0) begin
                p.v.x = XW'(y);
                p.v.y = -XW'(x);
                p.v.z = ZW'(QUARTER_TURN);
            end else begin
                p.v.x = -XW'(y);
                p.v.y = XW'(x);
                p.v.z = -ZW'(QUARTER_TURN);
            end
        end else begin
            p.v.x = XW'(x);
            p.v.y = XW'(y);
            p.v.z = '0;
        end
        return p;
    endfunction

    function automatic logic [15:0] ang16(input logic signed [ZW-1:0] a);
        logic signed [ZW-1:0] t;
        t = a + ZW'(32768);
        return t[31:16];
    endfunction

    function automatic logic signed [35:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd134217728;
        return p[63:28];
    endfunction

    function automatic logic [15:0] qsat(input logic signed [68:0] s);
        logic signed [68:0] t;
        logic signed [26:0] v;
        t = s + (69'sd1 <<< 41);
        v = t[68:42];
        if (v > 27'sd16384) begin
            v = 27'sd16384;
        end else if (v < -27'sd16384) begin
            v = -27'sd16384;
        end
        return v[15:0];
    endfunction

    logic ce;
    logic [LAT-1:0] vld_reg;

    // Euler term products
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    logic signed [15:0] qw, qx, qy, qz;
    term_t              t2_next;
    term_t              t2_reg;
    logic signed [28:0] sinp_lim;
    logic signed [57:0] sinp_sq;
    isq_t               isq_in_reg;
    isq_t               isq_d [SQN+1];
    term_t              term_reg [SQN+1];

    vec_t               vec_in_reg [3];
    vec_t               vec_d [3][N+1];
    vside_t             vside_reg [N+1];
    vec_t               rot_in_reg [3];
    vec_t               rot_d [3][N+1];
    aside_t             aside_reg [N+3];

    pre_t               pre_c [3];
    logic signed [ZW-1:0] roll_a, pitch_a, yaw_a;
    logic signed [ZW-1:0] pt;
    logic signed [17:0] p16;
    aside_t             aside_next;

    logic signed [31:0] cy, sy, cp, sp, cr, sr;
    logic signed [35:0] cycp_reg, sysp_reg, sycp_reg, cysp_reg;
    logic signed [31:0] cr_reg, sr_reg;
    logic signed [67:0] prod_reg [8];
    logic [111:0]       item_data;
    logic               item_in;

    logic [111:0]       out_data_reg, skid_data_reg;
    logic               out_sat_reg, skid_sat_reg;
    logic               out_valid_reg, skid_valid_reg;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // stage: products
    always_ff @(posedge aclk) begin
        if (ce) begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
        end
    end

    // stage: Euler terms in Q.28
    always_comb begin
        t2_next.sinr = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        t2_next.cosr = TW'(Q28_ONE) - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        t2_next.sinp = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
        t2_next.siny = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        t2_next.cosy = TW'(Q28_ONE) - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        t2_next.sat  = (t2_next.sinp >= TW'(Q28_ONE)) || (t2_next.sinp <= -TW'(Q28_ONE));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t2_reg <= t2_next;
        end
    end

    // stage: 1 - sinp^2; a clamped pitch needs no root, so feed zero
    assign sinp_lim = t2_reg.sat ? '0 : t2_reg.sinp[28:0];
    assign sinp_sq  = sinp_lim * sinp_lim;

    always_ff @(posedge aclk) begin
        if (ce) begin
            isq_in_reg.v <= (SQW'(1) << 56) - unsigned'(sinp_sq);
            isq_in_reg.r <= '0;
            term_reg[0]  <= t2_reg;
            for (int i = 1; i <= SQN; i++) begin
                term_reg[i] <= term_reg[i-1];
            end
        end
    end

    assign isq_d[0] = isq_in_reg;

    for (genvar i = 0; i < SQN; i++) begin : g_sqrt
        qer_isqrt_cell #(.K(SQN - 1 - i)) u_cell (
            .aclk  (aclk),
            .ce    (ce),
            .d_in  (isq_d[i]),
            .d_out (isq_d[i+1])
        );
    end

    // stage: quadrant fold into the right half plane
    always_comb begin
        pre_c[0] = prerot(term_reg[SQN].sinr, term_reg[SQN].cosr);
        pre_c[1] = prerot(term_reg[SQN].sinp,
                          signed'({{(TW-29){1'b0}}, isq_d[SQN].r[28:0]}));
        pre_c[2] = prerot(term_reg[SQN].siny, term_reg[SQN].cosy);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < 3; l++) begin
                vec_in_reg[l]     <= pre_c[l].v;
                vside_reg[0].zero[l] <= pre_c[l].zero;
            end
            vside_reg[0].sat <= term_reg[SQN].sat;
            vside_reg[0].pos <= (term_reg[SQN].sinp > 0);
            for (int i = 1; i <= N; i++) begin
                vside_reg[i] <= vside_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_vec_lane
        assign vec_d[l][0] = vec_in_reg[l];
        for (genvar i = 0; i < N; i++) begin : g_vec
            qer_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
                .aclk  (aclk),
                .ce    (ce),
                .d_in  (vec_d[l][i]),
                .d_out (vec_d[l][i+1])
            );
        end
    end

    // stage: pick angles, round them out, halve them for the rotation chain
    always_comb begin
        roll_a = vside_reg[N].zero[0] ? '0 : vec_d[0][N].z;
        yaw_a  = vside_reg[N].zero[2] ? '0 : vec_d[2][N].z;
        if (vside_reg[N].sat) begin
            pitch_a = vside_reg[N].pos ? ZW'(QUARTER_TURN) : -ZW'(QUARTER_TURN);
        end else begin
            pitch_a = vside_reg[N].zero[1] ? '0 : vec_d[1][N].z;
        end
        pt  = pitch_a + ZW'(32768);
        p16 = pt[ZW-1:16];
        if (p16 > 18'sd16384) begin
            p16 = 18'sd16384;
        end else if (p16 < -18'sd16384) begin
            p16 = -18'sd16384;
        end
        aside_next.roll  = ang16(roll_a);
        aside_next.pitch = p16[15:0];
        aside_next.yaw   = ang16(yaw_a);
        aside_next.sat   = vside_reg[N].sat;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rot_in_reg[0] <= '{x: XW'(CORDIC_GAIN), y: '0, z: roll_a >>> 1};
            rot_in_reg[1] <= '{x: XW'(CORDIC_GAIN), y: '0, z: pitch_a >>> 1};
            rot_in_reg[2] <= '{x: XW'(CORDIC_GAIN), y: '0, z: yaw_a >>> 1};
            aside_reg[0]  <= aside_next;
            for (int i = 1; i < N + 3; i++) begin
                aside_reg[i] <= aside_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_rot_lane
        assign rot_d[l][0] = rot_in_reg[l];
        for (genvar i = 0; i < N; i++) begin : g_rot
            qer_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
                .aclk  (aclk),
                .ce    (ce),
                .d_in  (rot_d[l][i]),
                .d_out (rot_d[l][i+1])
            );
        end
    end

    // stage: pairwise half-angle products, pitch and yaw sines negated
    always_comb begin
        cr = rot_d[0][N].x[31:0];
        sr = rot_d[0][N].y[31:0];
        cp = rot_d[1][N].x[31:0];
        sp = -rot_d[1][N].y[31:0];
        cy = rot_d[2][N].x[31:0];
        sy = -rot_d[2][N].y[31:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cycp_reg <= mulq(cy, cp);
            sysp_reg <= mulq(sy, sp);
            sycp_reg <= mulq(sy, cp);
            cysp_reg <= mulq(cy, sp);
            cr_reg   <= cr;
            sr_reg   <= sr;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg[0] <= cycp_reg * cr_reg;
            prod_reg[1] <= sysp_reg * sr_reg;
            prod_reg[2] <= cycp_reg * sr_reg;
            prod_reg[3] <= sysp_reg * cr_reg;
            prod_reg[4] <= sycp_reg * sr_reg;
            prod_reg[5] <= cysp_reg * cr_reg;
            prod_reg[6] <= sycp_reg * cr_reg;
            prod_reg[7] <= cysp_reg * sr_reg;
        end
    end

    always_comb begin
        item_data[15:0]   = aside_reg[N+2].roll;
        item_data[31:16]  = aside_reg[N+2].pitch;
        item_data[47:32]  = aside_reg[N+2].yaw;
        item_data[63:48]  = qsat(69'(prod_reg[0]) + 69'(prod_reg[1]));
        item_data[79:64]  = qsat(69'(prod_reg[2]) - 69'(prod_reg[3]));
        item_data[95:80]  = qsat(69'(prod_reg[4]) + 69'(prod_reg[5]));
        item_data[111:96] = qsat(69'(prod_reg[6]) - 69'(prod_reg[7]));
    end

    assign item_in = ce && vld_reg[LAT-1];

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (item_in) begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_sat_reg  <= skid_sat_reg;
            end
        end else if (item_in) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= item_data;
                out_sat_reg  <= aside_reg[N+2].sat;
            end else begin
                skid_data_reg <= item_data;
                skid_sat_reg  <= aside_reg[N+2].sat;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("skid entry lost while output stalled");

    a_sat_quarter: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_sat_reg |->
            (out_data_reg[31:16] == 16'h4000 || out_data_reg[31:16] == 16'hC000))
        else $error("saturated pitch is not a quarter turn");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            ($signed(out_data_reg[31:16]) <= 16'sd16384
             && $signed(out_data_reg[31:16]) >= -16'sd16384))
        else $error("pitch out of range");
`endif

endmodule

`default_nettype wire

@@ dv/quaternion_euler_reframe_tb.sv @@
// Testbench for quaternion_euler_reframe: directed table plus random quaternions, scoreboard.
`timescale 1ns / 1ps

module quaternion_euler_reframe_tb;

    localparam int NST       = (qer_pkg::CORDIC_STAGES_DEF > qer_pkg::ATAN_LEN) ?
                               qer_pkg::ATAN_LEN : qer_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY   = 36 + 2 * qer_pkg::CORDIC_STAGES_DEF;
    localparam int N_RANDOM  = 1600;
    localparam int IDLE_LIMIT = 4000;
    localparam longint ONE_Q28  = qer_pkg::Q28_ONE;
    localparam longint QTURN    = qer_pkg::QUARTER_TURN;
    localparam longint GAIN_Q28 = qer_pkg::CORDIC_GAIN;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               sat;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } attitude_t;

    typedef struct {
        shortint w, x, y, z;
        bit      pinned;      // pitch and clamp flag typed in below
        shortint pitch;
        bit      sat;
    } quat_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [0:0]   m_tuser;

    attitude_t expected_q[$];
    attitude_t pending_exp;
    int        errors = 0;
    int        n_sent = 0;
    int        n_recv = 0;
    int        n_sat = 0;
    int        idle_cycles = 0;
    bit        calm = 1'b0;
    bit        out_calm = 1'b0;

    always #5 aclk = ~aclk;

    quaternion_euler_reframe u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // vectoring rotation: angle of (x,y), 2^31 = pi
    function automatic longint vector_angle(input longint y, input longint x);
        longint acc, t, dx, dy;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = QTURN;
            end else begin
                t = x; x = -y; y = t; acc = -QTURN;
            end
        end
        for (int i = 0; i < NST; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += qer_pkg::atan_entry(i);
            end else begin
                x -= dx; y += dy; acc -= qer_pkg::atan_entry(i);
            end
        end
        return acc;
    endfunction

    function automatic void half_sincos(input longint a, output longint c, output longint s);
        longint x, y, dx, dy;
        x = GAIN_Q28;
        y = 0;
        for (int i = 0; i < NST; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                x -= dx; y += dy; a -= qer_pkg::atan_entry(i);
            end else begin
                x += dx; y -= dy; a += qer_pkg::atan_entry(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint prod_q28(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic logic signed [15:0] round_quat(input longint s56);
        longint v;
        v = (s56 + (64'sd1 <<< 41)) >>> 42;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function automatic attitude_t reframe_quat(input shortint iw, input shortint ix,
                                               input shortint iy, input shortint iz);
        longint w, x, y, z, sinr, cosr, sinp, siny, cosy, roll, pitch, yaw, p16, ar, ay;
        longint cr, sr, cp, sp, cy, sy, cycp, sysp, sycp, cysp;
        longint unsigned rem;
        attitude_t r;
        w = iw; x = ix; y = iy; z = iz;
        sinr = 2 * (w * x + y * z);
        cosr = ONE_Q28 - 2 * (x * x + y * y);
        sinp = 2 * (w * y - z * x);
        siny = 2 * (w * z + x * y);
        cosy = ONE_Q28 - 2 * (y * y + z * z);
        roll = vector_angle(sinr, cosr);
        yaw  = vector_angle(siny, cosy);
        r.sat = (sinp >= ONE_Q28) || (sinp <= -ONE_Q28);
        if (r.sat) begin
            pitch = (sinp > 0) ? QTURN : -QTURN;
        end else begin
            rem = (64'd1 << 56) - longint'(sinp * sinp);
            pitch = vector_angle(sinp, longint'(root64(rem)));
        end
        half_sincos(yaw >>> 1, cy, sy);
        sy = -sy;
        half_sincos(pitch >>> 1, cp, sp);
        sp = -sp;
        half_sincos(roll >>> 1, cr, sr);
        cycp = prod_q28(cy, cp);
        sysp = prod_q28(sy, sp);
        sycp = prod_q28(sy, cp);
        cysp = prod_q28(cy, sp);
        p16 = (pitch + 32768) >>> 16;
        if (p16 > 16384) p16 = 16384;
        if (p16 < -16384) p16 = -16384;
        ar = (roll + 32768) >>> 16;
        ay = (yaw + 32768) >>> 16;
        r.roll  = ar[15:0];
        r.pitch = p16[15:0];
        r.yaw   = ay[15:0];
        r.qw = round_quat(cycp * cr + sysp * sr);
        r.qx = round_quat(cycp * sr - sysp * cr);
        r.qy = round_quat(sycp * sr + cysp * cr);
        r.qz = round_quat(sycp * cr - cysp * sr);
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // drive one quaternion and hold it until the transfer completes
    task automatic send_quat(input shortint w, input shortint x, input shortint y,
                             input shortint z, input attitude_t exp_r);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {z, y, x, w};
        pending_exp = exp_r;
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
    endtask

    task automatic send_checked(input shortint w, input shortint x, input shortint y,
                                input shortint z);
        send_quat(w, x, y, z, reframe_quat(w, x, y, z));
    endtask

    function automatic shortint to_q14(input real v);
        return shortint'($rtoi(v >= 0.0 ? v * 16384.0 + 0.5 : v * 16384.0 - 0.5));
    endfunction

    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $urandom_range(0, 65535) / 32768.0 - 1.0;
        b = $urandom_range(0, 65535) / 32768.0 - 1.0;
        c = $urandom_range(0, 65535) / 32768.0 - 1.0;
        d = $urandom_range(0, 65535) / 32768.0 - 1.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0e-3) begin
            a = 1.0; n = 1.0;
        end
        send_checked(to_q14(a / n), to_q14(b / n), to_q14(c / n), to_q14(d / n));
    endtask

    // output side: random stalls, with quiet stretches
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!out_calm && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // sample mid-cycle: inputs change only at the rising edge
    always @(negedge aclk) begin
        attitude_t e;
        logic signed [15:0] g_roll, g_pitch, g_yaw, g_w, g_x, g_y, g_z;
        bit moved;
        moved = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            expected_q.push_back(pending_exp);
            n_sent++;
            moved = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1'b1;
            {g_z, g_y, g_x, g_w, g_yaw, g_pitch, g_roll} = m_tdata;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h / %b", $time, m_tdata, m_tuser);
            end else begin
                e = expected_q.pop_front();
                n_recv++;
                if (m_tuser[0]) n_sat++;
                if (g_roll !== e.roll || g_pitch !== e.pitch || g_yaw !== e.yaw ||
                    m_tuser[0] !== e.sat || g_w !== e.qw || g_x !== e.qx ||
                    g_y !== e.qy || g_z !== e.qz) begin
                    errors++;
                    $display("%0t: mismatch exp rpy %0d %0d %0d sat %0d q %0d %0d %0d %0d",
                             $time, e.roll, e.pitch, e.yaw, e.sat, e.qw, e.qx, e.qy, e.qz);
                    $display("%0t:          got rpy %0d %0d %0d sat %0d q %0d %0d %0d %0d",
                             $time, g_roll, g_pitch, g_yaw, m_tuser[0], g_w, g_x, g_y, g_z);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    quat_row_t rows[] = '{
        '{16384, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0},
        '{-16384, 0, 0, 0, 0, 0, 0},
        '{0, 16384, 0, 0, 0, 0, 0},          // roll at pi
        '{0, -16384, 0, 0, 0, 0, 0},
        '{0, 0, 0, 16384, 0, 0, 0},          // yaw at pi
        '{0, 0, 0, -16384, 0, 0, 0},
        '{0, 0, 16384, 0, 1, 0, 0},
        '{16384, 0, 16384, 0, 1, 16384, 1},  // pitch clamped up
        '{16384, 0, -16384, 0, 1, -16384, 1},
        '{-16384, 0, 16384, 0, 1, -16384, 1},
        '{11585, 0, 11585, 0, 0, 0, 0},      // just under the clamp
        '{11586, 0, 11586, 0, 1, 16384, 1},
        '{0, 16384, 0, 16384, 1, -16384, 1},
        '{16384, 16384, 16384, 16384, 0, 0, 0},
        '{-16384, -16384, -16384, -16384, 0, 0, 0},
        '{32767, 32767, 32767, 32767, 0, 0, 0},
        '{-32768, -32768, -32768, -32768, 0, 0, 0},
        '{-32768, 32767, -32768, 32767, 0, 0, 0},
        '{8192, 8192, 8192, 8192, 0, 0, 0},
        '{8192, -8192, 8192, -8192, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0, 0},
        '{-1, -1, -1, -1, 0, 0, 0}
    };

    initial begin
        attitude_t e;
        int p;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            e = reframe_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z);
            if (rows[i].pinned) begin
                e.pitch = rows[i].pitch;
                e.sat   = rows[i].sat;
            end
            send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z, e);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // alternate busy and quiet stretches on both sides
            if (i % 200 == 0) begin
                calm     = ($urandom_range(0, 2) == 0);
                out_calm = ($urandom_range(0, 2) == 0);
            end
            p = $urandom_range(0, 99);
            if (p < 70) begin
                send_unit_quat();
            end else if (p < 85) begin
                // near gimbal lock, either side of the clamp
                send_checked(shortint'($urandom_range(11575, 11595)),
                             shortint'(int'($urandom_range(0, 40)) - 20),
                             shortint'((p & 1) ? -int'($urandom_range(11575, 11595))
                                               : int'($urandom_range(11575, 11595))),
                             shortint'(int'($urandom_range(0, 40)) - 20));
            end else if (p < 93) begin
                send_checked(shortint'(int'($urandom_range(0, 32768)) - 16384),
                             shortint'(int'($urandom_range(0, 32768)) - 16384),
                             shortint'(int'($urandom_range(0, 32768)) - 16384),
                             shortint'(int'($urandom_range(0, 32768)) - 16384));
            end else begin
                send_checked(shortint'($urandom), shortint'($urandom),
                             shortint'($urandom), shortint'($urandom));
            end
        end
        s_tvalid <= 1'b0;
        out_calm = 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);

        $display("Sent %0d quaternions, checked %0d results, %0d with pitch clamped.",
                 n_sent, n_recv, n_sat);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
